[rtl/core/stt_pkg.sv]
// Package for the source token scanner: scan modes, result and state types,
// character class helpers and the per-character scan function.
// No dependencies.
package stt_pkg;

    localparam int LINE_LENGTH_DEF = 256;

    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_DEC  = 3'd1;
    localparam logic [2:0] MODE_HEX0 = 3'd2;
    localparam logic [2:0] MODE_HEXX = 3'd3;
    localparam logic [2:0] MODE_HEXD = 3'd4;
    localparam logic [2:0] MODE_SUF  = 3'd5;
    localparam logic [2:0] MODE_WORD = 3'd6;
    localparam logic [2:0] MODE_OP   = 3'd7;

    localparam logic [1:0] CLS_NUMBER = 2'd0;
    localparam logic [1:0] CLS_TEXT   = 2'd1;
    localparam logic [1:0] CLS_FUNC   = 2'd2;
    localparam logic [1:0] CLS_TYPE   = 2'd3;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] start;
        logic       first_cap;
    } t_scan;

    typedef struct packed {
        logic [7:0] token_start;
        logic [8:0] token_end;
        logic [1:0] token_class;
        logic       is_operator;
        logic       last_of_line;
    } t_result;

    typedef struct packed {
        t_scan   st;
        logic    emit;
        t_result res;
    } t_exam;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

    function automatic logic is_numeral(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_upper(logic [7:0] c);
        return (c >= "A") && (c <= "Z");
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return is_upper(c) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic is_xdigit(logic [7:0] c);
        return is_numeral(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    endfunction

    function automatic logic is_punct(logic [7:0] c);
        return (c >= 8'd33) && (c <= 8'd126) && !is_alpha(c) && !is_numeral(c);
    endfunction

    function automatic logic is_suffix(logic [7:0] c);
        return (c == "f") || (c == "F") || (c == "u") || (c == "U") ||
               (c == "l") || (c == "L");
    endfunction

    function automatic logic op_pair(logic [7:0] a, logic [7:0] b);
        return ((a == "=") && ((b == "=") || (b == ">"))) ||
               ((a == "!") && (b == "=")) ||
               ((a == "<") && ((b == "=") || (b == "<") || (b == ">"))) ||
               ((a == ">") && ((b == "=") || (b == ">"))) ||
               ((a == "&") && (b == "&")) ||
               ((a == "|") && (b == "|")) ||
               ((a == "+") && (b == "+")) ||
               ((a == "-") && ((b == "-") || (b == ">"))) ||
               ((a == ":") && (b == ":")) ||
               ((a == ".") && (b == "."));
    endfunction

    // Examine character h with lookahead c at line index idx8 (end9 = idx + 1).
    function automatic t_exam scan_examine(t_scan st, logic [7:0] h, logic [7:0] c,
                                           logic have_c, logic [7:0] idx8,
                                           logic [8:0] end9, logic cap_type);
        t_exam      e;
        logic [2:0] m;
        logic [2:0] nx;
        logic       go;
        e      = '0;
        e.st   = st;
        m      = st.mode;
        go     = 1'b1;
        nx     = MODE_IDLE;
        if (m == MODE_IDLE) begin
            e.st.start = idx8;
            if (is_numeral(h) || ((h == ".") && have_c && is_numeral(c))) begin
                m = ((h == "0") && have_c && ((c == "x") || (c == "X"))) ? MODE_HEX0
                                                                          : MODE_DEC;
            end else if (is_alpha(h) || (h == "_")) begin
                m = MODE_WORD;
                e.st.first_cap = is_upper(h);
            end else if (is_punct(h)) begin
                m = MODE_OP;
            end else begin
                go = 1'b0;
            end
        end
        case (m)
            MODE_IDLE: nx = MODE_IDLE;
            MODE_DEC: begin
                if (is_numeral(c) || (c == ".") || (c == "_") || (c == "e") || (c == "E") ||
                    (((c == "+") || (c == "-")) && ((h == "e") || (h == "E"))))
                    nx = MODE_DEC;
                else if (is_suffix(c))
                    nx = MODE_SUF;
            end
            MODE_HEX0: nx = MODE_HEXX;
            MODE_HEXX, MODE_HEXD: begin
                if (is_xdigit(c))
                    nx = MODE_HEXD;
                else if (is_suffix(c))
                    nx = MODE_SUF;
            end
            MODE_SUF: begin
                if (is_suffix(c))
                    nx = MODE_SUF;
            end
            MODE_WORD: begin
                if (is_alpha(c) || is_numeral(c) || (c == "_"))
                    nx = MODE_WORD;
            end
            default: begin
                if (op_pair(h, c))
                    nx = MODE_OP;
            end
        endcase
        if (!have_c)
            nx = MODE_IDLE;
        if (go) begin
            e.st.mode = nx;
            if (nx == MODE_IDLE) begin
                e.emit              = 1'b1;
                e.res.token_start   = e.st.start;
                e.res.token_end     = end9;
                e.res.token_class   = CLS_NUMBER;
                e.res.is_operator   = 1'b0;
                e.res.last_of_line  = 1'b0;
                if (m == MODE_OP) begin
                    e.res.is_operator = 1'b1;
                end else if (m == MODE_WORD) begin
                    if (have_c && (c == "("))
                        e.res.token_class = CLS_FUNC;
                    else if (e.st.first_cap && cap_type)
                        e.res.token_class = CLS_TYPE;
                    else
                        e.res.token_class = CLS_TEXT;
                end
            end
        end
        return e;
    endfunction

endpackage

[rtl/core/stt_core.sv]
// Scanner state and per-item token logic: held character, line position,
// scan mode; produces up to two results per item. Depends on stt_pkg.
module stt_core #(
    parameter int LINE_LENGTH = stt_pkg::LINE_LENGTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_char_code,
    input  logic          i_line_end,
    input  logic          i_cap_type,
    output stt_pkg::t_push o_push
);
    import stt_pkg::*;

    localparam int PW = $clog2(LINE_LENGTH);
    localparam logic [PW-1:0] LAST_POS = PW'(LINE_LENGTH - 1);

    t_scan         r_st, n_st;
    logic [PW-1:0] r_pos, n_pos;
    logic [7:0]    r_held, n_held;
    logic          r_held_v, n_held_v;

    logic          last;
    logic [PW-1:0] idx_h;
    logic [PW+8:0] ext_h, ext_c;
    logic [8:0]    idx9_h, idx9_c;
    t_exam         e1, e2;
    t_push         push;

    always_comb begin
        last   = i_line_end || (r_pos >= LAST_POS);
        idx_h  = r_pos - PW'(1);
        ext_h  = {9'd0, idx_h};
        ext_c  = {9'd0, r_pos};
        idx9_h = ext_h[8:0];
        idx9_c = ext_c[8:0];

        if (r_held_v)
            e1 = scan_examine(r_st, r_held, i_char_code, 1'b1, idx9_h[7:0],
                              9'(idx9_h + 9'd1), i_cap_type);
        else begin
            e1      = '0;
            e1.st   = r_st;
        end
        e2 = scan_examine(e1.st, i_char_code, 8'd0, 1'b0, idx9_c[7:0],
                          9'(idx9_c + 9'd1), i_cap_type);

        push      = '0;
        push.res0 = e1.emit ? e1.res : e2.res;
        push.res1 = e2.res;
        if (last) begin
            push.count = 2'(e1.emit) + 2'(e2.emit);
            if (e2.emit) begin
                push.res0.last_of_line = !e1.emit;
                push.res1.last_of_line = 1'b1;
            end else begin
                push.res0.last_of_line = 1'b1;
            end
        end else begin
            push.count = 2'(e1.emit);
        end
        if (!i_accept)
            push.count = 2'd0;

        n_st     = r_st;
        n_pos    = r_pos;
        n_held   = r_held;
        n_held_v = r_held_v;
        if (i_accept) begin
            if (last) begin
                n_st      = e2.st;
                n_st.mode = MODE_IDLE;
                n_pos     = '0;
                n_held    = 8'd0;
                n_held_v  = 1'b0;
            end else begin
                n_st     = e1.st;
                n_pos    = r_pos + PW'(1);
                n_held   = i_char_code;
                n_held_v = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= '0;
            r_pos    <= '0;
            r_held   <= 8'd0;
            r_held_v <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_pos    <= n_pos;
            r_held   <= n_held;
            r_held_v <= n_held_v;
        end
    end

    assign o_push = push;

endmodule

[rtl/core/stt_queue.sv]
// Four-entry result queue: takes up to two results a cycle, hands out one.
// Depends on stt_pkg.
module stt_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  stt_pkg::t_push   i_push,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output stt_pkg::t_result o_head
);
    import stt_pkg::*;

    t_result    r_mem [4];
    logic [1:0] r_wp, n_wp;
    logic [1:0] r_rp, n_rp;
    logic [2:0] r_cnt, n_cnt;
    logic [1:0] wp1;

    always_comb begin
        wp1   = r_wp + 2'd1;
        n_wp  = r_wp + i_push.count;
        n_rp  = i_pop ? (r_rp + 2'd1) : r_rp;
        n_cnt = 3'(r_cnt + 3'(i_push.count) - 3'(i_pop));
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0)
            r_mem[r_wp] <= i_push.res0;
        if (i_push.count == 2'd2)
            r_mem[wp1] <= i_push.res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // room for two results must exist before an item is taken
    assign o_full  = r_cnt > 3'd2;
    assign o_valid = r_cnt != 3'd0;
    assign o_head  = r_mem[r_rp];

endmodule

[rtl/core/source_token_scanner.sv]
// Top level of the source token scanner: config register, scanner core and
// result queue. Depends on stt_pkg, stt_core, stt_queue.
//
//   channel | direction | handshake              | payload
//   cfg     | in        | i_cfg_valid/o_cfg_ready | i_cfg_data (capital_is_type)
//   in      | in        | i_in_valid/o_in_stall   | i_char_code, i_line_end
//   out     | out       | o_out_valid/i_out_stall | o_token_*, o_is_operator, o_last_of_line
//
// One item per cycle while o_in_stall is low; results are registered into a
// four-entry queue. An item yields zero, one or two results; the output side
// moves one result per cycle while i_out_stall is low, so two-result items can hold off input via o_in_stall.
// Synchronous active-low reset clears position, scan mode and the queue.
module source_token_scanner #(
    parameter int LINE_LENGTH = stt_pkg::LINE_LENGTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_char_code,
    input  logic       i_line_end,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_token_start,
    output logic [8:0] o_token_end,
    output logic [1:0] o_token_class,
    output logic       o_is_operator,
    output logic       o_last_of_line
);
    import stt_pkg::*;

    logic    r_cap_type;
    logic    full;
    logic    accept;
    logic    pop;
    t_push   push;
    t_result head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_type <= 1'b0;
        end else if (i_cfg_valid) begin
            r_cap_type <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = full;
    assign accept      = i_in_valid && !full;
    assign pop         = o_out_valid && !i_out_stall;

    stt_core #(
        .LINE_LENGTH(LINE_LENGTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_char_code(i_char_code),
        .i_line_end (i_line_end),
        .i_cap_type (r_cap_type),
        .o_push     (push)
    );

    stt_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_pop  (pop),
        .o_full (full),
        .o_valid(o_out_valid),
        .o_head (head)
    );

    assign o_token_start  = head.token_start;
    assign o_token_end    = head.token_end;
    assign o_token_class  = head.token_class;
    assign o_is_operator  = head.is_operator;
    assign o_last_of_line = head.last_of_line;

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for source_token_scanner: a token predictor in a small
// scoreboard class, random idling on both sides, watchdog. Depends on stt_pkg.
module testbench;
    import stt_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE      = 4;

    class token_board;
        localparam int LINE_LEN = stt_pkg::LINE_LENGTH_DEF;

        stt_pkg::t_result expected_tokens[$];
        stt_pkg::t_result step_tokens[$];
        bit               cap_type;
        logic [8:0]       col;
        logic [2:0]       mode;
        logic [7:0]       tok_from;
        logic [7:0]       held;
        bit               held_ok;
        bit               first_cap;
        int               fails;

        function new();
            cap_type  = 1'b0;
            col       = '0;
            mode      = MODE_IDLE;
            tok_from  = '0;
            held      = '0;
            held_ok   = 1'b0;
            first_cap = 1'b0;
            fails     = 0;
        endfunction

        function bit digit_ch(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit upper_ch(logic [7:0] c);
            return c >= "A" && c <= "Z";
        endfunction

        function bit letter_ch(logic [7:0] c);
            return upper_ch(c) || (c >= "a" && c <= "z");
        endfunction

        function bit hex_ch(logic [7:0] c);
            return digit_ch(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
        endfunction

        function bit punct_ch(logic [7:0] c);
            return c >= 8'd33 && c <= 8'd126 && !letter_ch(c) && !digit_ch(c);
        endfunction

        function bit suffix_ch(logic [7:0] c);
            return c == "f" || c == "F" || c == "u" || c == "U" || c == "l" || c == "L";
        endfunction

        function bit joins_op(logic [7:0] a, logic [7:0] b);
            case (a)
                "=":     return b == "=" || b == ">";
                "!":     return b == "=";
                "<":     return b == "=" || b == "<" || b == ">";
                ">":     return b == "=" || b == ">";
                "&":     return b == "&";
                "|":     return b == "|";
                "+":     return b == "+";
                "-":     return b == "-" || b == ">";
                ":":     return b == ":";
                ".":     return b == ".";
                default: return 1'b0;
            endcase
        endfunction

        // h is the character under test, c its lookahead (absent at line end).
        function void scan_char(logic [7:0] h, logic [7:0] c, bit have_c, logic [8:0] idx);
            logic [2:0]       cur;
            logic [2:0]       nxt;
            stt_pkg::t_result r;
            cur = mode;
            nxt = MODE_IDLE;
            if (cur == MODE_IDLE) begin
                tok_from = idx[7:0];
                if (digit_ch(h) || (h == "." && have_c && digit_ch(c))) begin
                    cur = (h == "0" && have_c && (c == "x" || c == "X")) ? MODE_HEX0 : MODE_DEC;
                end else if (letter_ch(h) || h == "_") begin
                    cur       = MODE_WORD;
                    first_cap = upper_ch(h);
                end else if (punct_ch(h)) begin
                    cur = MODE_OP;
                end else begin
                    return;
                end
            end
            case (cur)
                MODE_DEC: begin
                    if (digit_ch(c) || c == "." || c == "_" || c == "e" || c == "E" ||
                        ((c == "+" || c == "-") && (h == "e" || h == "E")))
                        nxt = MODE_DEC;
                    else if (suffix_ch(c))
                        nxt = MODE_SUF;
                end
                MODE_HEX0: nxt = MODE_HEXX;
                MODE_HEXX, MODE_HEXD: begin
                    if (hex_ch(c))
                        nxt = MODE_HEXD;
                    else if (suffix_ch(c))
                        nxt = MODE_SUF;
                end
                MODE_SUF: begin
                    if (suffix_ch(c))
                        nxt = MODE_SUF;
                end
                MODE_WORD: begin
                    if (letter_ch(c) || digit_ch(c) || c == "_")
                        nxt = MODE_WORD;
                end
                default: begin
                    if (joins_op(h, c))
                        nxt = MODE_OP;
                end
            endcase
            if (!have_c)
                nxt = MODE_IDLE;
            if (nxt == MODE_IDLE) begin
                r.token_start  = tok_from;
                r.token_end    = idx + 9'd1;
                r.token_class  = CLS_NUMBER;
                r.is_operator  = 1'b0;
                r.last_of_line = 1'b0;
                if (cur == MODE_OP) begin
                    r.is_operator = 1'b1;
                end else if (cur == MODE_WORD) begin
                    if (have_c && c == "(")
                        r.token_class = CLS_FUNC;
                    else if (first_cap && cap_type)
                        r.token_class = CLS_TYPE;
                    else
                        r.token_class = CLS_TEXT;
                end
                step_tokens.push_back(r);
            end
            mode = nxt;
        endfunction

        function void take_char(logic [7:0] c, logic le);
            stt_pkg::t_result r;
            bit               line_done;
            line_done = le || (col >= LINE_LEN - 1);
            step_tokens.delete();
            if (held_ok && col > 0)
                scan_char(held, c, 1'b1, col - 9'd1);
            if (line_done) begin
                scan_char(c, 8'h00, 1'b0, col);
                if (step_tokens.size() > 0) begin
                    r              = step_tokens.pop_back();
                    r.last_of_line = 1'b1;
                    step_tokens.push_back(r);
                end
                col     = '0;
                mode    = MODE_IDLE;
                held    = '0;
                held_ok = 1'b0;
            end else begin
                held    = c;
                held_ok = 1'b1;
                col     = col + 9'd1;
            end
            foreach (step_tokens[i])
                expected_tokens.push_back(step_tokens[i]);
        endfunction

        function string describe(stt_pkg::t_result t);
            return $sformatf("start %0d end %0d class %0d op %0b last %0b",
                             t.token_start, t.token_end, t.token_class,
                             t.is_operator, t.last_of_line);
        endfunction

        function void flag(string msg);
            fails++;
            if (fails <= 10)
                $display("%s", msg);
        endfunction

        function void check_token(stt_pkg::t_result got);
            stt_pkg::t_result want;
            if (expected_tokens.size() == 0) begin
                flag($sformatf("unexpected token: %s", describe(got)));
                return;
            end
            want = expected_tokens.pop_front();
            if (got.token_start != want.token_start || got.token_end != want.token_end ||
                got.token_class != want.token_class || got.is_operator != want.is_operator ||
                got.last_of_line != want.last_of_line)
                flag($sformatf("token mismatch: expected %s, got %s",
                               describe(want), describe(got)));
        endfunction
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_data  = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] char_code = 8'h00;
    logic       line_end  = 1'b0;
    logic       out_stall = 1'b0;
    logic       calm      = 1'b0;

    logic             o_cfg_ready;
    logic             o_in_stall;
    logic             o_out_valid;
    logic [7:0]       o_token_start;
    logic [8:0]       o_token_end;
    logic [1:0]       o_token_class;
    logic             o_is_operator;
    logic             o_last_of_line;
    stt_pkg::t_result seen;

    token_board board = new();
    logic [7:0] line_chars[$];
    int         sent  = 0;
    int         quiet = 0;

    assign seen = {o_token_start, o_token_end, o_token_class, o_is_operator, o_last_of_line};

    source_token_scanner dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_char_code    (char_code),
        .i_line_end     (line_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_token_start  (o_token_start),
        .o_token_end    (o_token_end),
        .o_token_class  (o_token_class),
        .o_is_operator  (o_is_operator),
        .o_last_of_line (o_last_of_line)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        out_stall <= !calm && ($urandom_range(99) < 27);
    end

    always @(posedge clk) begin : watch
        bit moved;
        moved = 1'b0;
        if (rst_n) begin
            if (in_valid && !o_in_stall) begin
                board.take_char(char_code, line_end);
                moved = 1'b1;
            end
            if (o_out_valid && !out_stall) begin
                board.check_token(seen);
                moved = 1'b1;
            end
            if (cfg_valid && o_cfg_ready)
                moved = 1'b1;
        end
        quiet = moved ? 0 : quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic write_cap(input bit v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        cfg_valid      <= 1'b0;
        board.cap_type  = v;
    endtask

    task automatic send_item(input logic [7:0] c, input logic le);
        while (!calm && $urandom_range(99) < 27) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        line_end  <= le;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
        sent++;
    endtask

    task automatic send_line();
        foreach (line_chars[i])
            send_item(line_chars[i], i == line_chars.size() - 1);
        line_chars.delete();
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.expected_tokens.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_chars.push_back(s[i]);
    endfunction

    // Mostly well-formed tokens, abutting or space separated, with some noise.
    function automatic void add_token();
        string pairs;
        string sufs;
        string hexs;
        string tails;
        string opch;
        int    p;
        pairs = "===>!=<=<<<>>=>>&&||++---->::..";
        sufs  = "fFuUlL";
        hexs  = "0123456789abcdefABCDEFg";
        tails = "azAZmq_09k";
        opch  = "=<>-.:&|+!";
        if ($urandom_range(1))
            line_chars.push_back(" ");
        case ($urandom_range(9))
            0, 1: begin
                if ($urandom_range(3) == 0)
                    line_chars.push_back(".");
                repeat ($urandom_range(3, 1))
                    line_chars.push_back(8'h30 + 8'($urandom_range(9)));
                if ($urandom_range(2) == 0)
                    line_chars.push_back($urandom_range(1) ? "." : "_");
                if ($urandom_range(1)) begin
                    line_chars.push_back($urandom_range(1) ? "e" : "E");
                    if ($urandom_range(1))
                        line_chars.push_back($urandom_range(1) ? "+" : "-");
                    repeat ($urandom_range(2))
                        line_chars.push_back(8'h30 + 8'($urandom_range(9)));
                end
                repeat ($urandom_range(2))
                    line_chars.push_back(sufs[$urandom_range(5)]);
            end
            2: begin
                line_chars.push_back("0");
                line_chars.push_back($urandom_range(1) ? "x" : "X");
                repeat ($urandom_range(4))
                    line_chars.push_back(hexs[$urandom_range(22)]);
                repeat ($urandom_range(2))
                    line_chars.push_back(sufs[$urandom_range(5)]);
            end
            3, 4: begin
                case ($urandom_range(2))
                    0:       line_chars.push_back(8'h41 + 8'($urandom_range(25)));
                    1:       line_chars.push_back(8'h61 + 8'($urandom_range(25)));
                    default: line_chars.push_back("_");
                endcase
                repeat ($urandom_range(5))
                    line_chars.push_back(tails[$urandom_range(9)]);
                if ($urandom_range(2) == 0)
                    line_chars.push_back("(");
            end
            5, 6: begin
                p = $urandom_range(14);
                line_chars.push_back(pairs[2 * p]);
                line_chars.push_back(pairs[2 * p + 1]);
                if ($urandom_range(9) < 4)
                    line_chars.push_back(opch[$urandom_range(9)]);
            end
            7:       line_chars.push_back(8'($urandom_range(255)));
            8:       line_chars.push_back(8'($urandom_range(126, 32)));
            default: line_chars.push_back(8'($urandom_range(255, 128)));
        endcase
    endfunction

    task automatic random_items(input int n);
        int goal;
        int target;
        goal = sent + n;
        while (sent < goal) begin
            target = $urandom_range(24, 1);
            while (line_chars.size() < target) add_token();
            send_line();
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_cap(1'b1);
        add_text("0x1Fu...5e-3L");
        send_line();
        add_text(".5 Ty(Ab");
        send_line();
        line_chars.push_back(8'h00);
        line_chars.push_back(8'hFF);
        add_text("x");
        send_line();
        add_text(" ");
        send_line();
        wait_drained();

        write_cap(1'b0);
        random_items(20);
        wait_drained();

        write_cap(1'b1);
        calm <= 1'b1;
        random_items(20);
        // line longer than the scanner allows: forced line end at the last position
        while (line_chars.size() < 270) add_token();
        send_line();
        wait_drained();
        calm <= 1'b0;

        write_cap(1'b0);
        random_items(20);
        wait_drained();

        write_cap(1'b1);
        random_items(20);
        wait_drained();
        repeat (SETTLE) @(posedge clk);

        if (board.fails == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule

[files.f]
rtl/core/stt_pkg.sv
rtl/core/stt_core.sv
rtl/core/stt_queue.sv
rtl/core/source_token_scanner.sv
test/testbench.sv
